@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define ASSERT_CLK(name, clk, rst_n, prop)
`define ASSERT_NEXT(name, clk, rst_n, pre, post)
`endif

`endif

@@ rtl/ecal_pkg.sv @@
// ---------------------------------------------------------------------------
// ecal_pkg
// Shared constants and helpers of the encoder calibration table.
// ---------------------------------------------------------------------------
package ecal_pkg;

	// encoder counts per revolution is fixed at 2**CNT_W
	localparam int CNT_W      = 14;
	localparam int WRAP_LIMIT = 15000;
	localparam int FULL_TURN  = 360000;

	localparam logic [1:0] OP_SAMPLE  = 2'd0;
	localparam logic [1:0] OP_QUERY   = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	localparam logic [1:0] REG_SAMPLES = 2'd0;
	localparam logic [1:0] REG_STEPS   = 2'd1;
	localparam logic [1:0] REG_ANGLE   = 2'd2;

	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_INCOMPLETE = 2'd1;
	localparam logic [1:0] STAT_NO_INTERVAL = 2'd2;
	localparam logic [1:0] STAT_BACKWARDS  = 2'd3;

	typedef logic [CNT_W-1:0] count_t;
	typedef logic signed [CNT_W:0] diff_t;

	// signed step difference, wrapped by one revolution
	function automatic diff_t step_diff(input count_t from_c, input count_t to_c);
		diff_t d;
		d = diff_t'({1'b0, to_c}) - diff_t'({1'b0, from_c});
		if (d < -diff_t'(WRAP_LIMIT))
			d = d + diff_t'(2 ** CNT_W);
		else if (d > diff_t'(WRAP_LIMIT))
			d = d - diff_t'(2 ** CNT_W);
		return d;
	endfunction

endpackage

@@ rtl/encoder_calibration_table_core.sv @@
// ---------------------------------------------------------------------------
// encoder_calibration_table_core
// Averages raw encoder samples into one reading per full step, stores the
// readings in a RAM, and answers angle queries by interval scan and
// interpolation.
// ---------------------------------------------------------------------------
// One item in flight at a time. A sample closing a step group passes the shared
//   divider, then the RAM write.
// Query: sent straight to the output when incomplete or backwards, else interval scan,
//   then multiply, divide, add, modulo reduction and output.
// Reset: control, counters and flags clear, registers take 10/200/1800;
//   step readings are undefined until loaded.
module encoder_calibration_table_core #(
	parameter int MAX_STEPS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [13:0] sample_value, [27:14] query_count, zero pad
	input  logic [1:0]  s_tuser,   // [1:0] opcode
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [18:0] angle_mdeg, [20:19] status, zero pad
);

	localparam int SW   = $clog2(MAX_STEPS);          // RAM address bits
	localparam int LW   = SW + 1;                     // step counters
	localparam int EW   = (LW > 9) ? LW : 9;          // clamp compare width
	localparam int BW   = 16 + SW;                    // angle * step index
	localparam int AW   = BW + 1;                     // angle before modulo
	localparam int KTOP = AW - 18;                    // 360000 << KTOP exceeds any angle
	localparam int KW   = $clog2(KTOP + 1);
	localparam int DVW  = 30;                         // 16 x 14 product
	localparam int DSW  = ecal_pkg::CNT_W;            // divisor width

	localparam logic [AW:0] FULL_TURN_W = (AW + 1)'(ecal_pkg::FULL_TURN);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_RD0  = 9'b000000010,
		ST_SCAN = 9'b000000100,
		ST_MUL  = 9'b000001000,
		ST_DIV  = 9'b000010000,
		ST_ADD  = 9'b000100000,
		ST_RED  = 9'b001000000,
		ST_OUT  = 9'b010000000,
		ST_WR   = 9'b100000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [4:0]  samples_q;
	logic [8:0]  steps_q;
	logic [15:0] angle_q;

	// load state
	logic [LW-1:0]        loaded_q;
	logic [17:0]          sum_q;
	logic [4:0]           taken_q;
	logic                 back_q;
	ecal_pkg::count_t     first_q;   // reading of step 0, for the wiring check

	// query state
	ecal_pkg::count_t     q_q;
	ecal_pkg::count_t     r0_q;
	ecal_pkg::count_t     prev_q;
	logic [LW-1:0]        k_q;
	logic [SW-1:0]        i_q;
	ecal_pkg::count_t     j_q;
	logic [DSW-1:0]       ticks_q;
	logic [BW-1:0]        base_q;
	logic [AW-1:0]        ang_q;
	logic [KW-1:0]        red_k_q;
	logic [1:0]           stat_q;

	// shared restoring divider
	logic [DVW-1:0]       dvd_q;
	logic [DVW-1:0]       quo_q;
	logic [DSW-1:0]       dvs_q;
	logic [DSW-1:0]       rem_q;
	logic [4:0]           dcnt_q;
	logic                 div_query_q;

	// output register
	logic                 m_valid_q;
	logic [18:0]          m_angle_q;
	logic [1:0]           m_stat_q;

	// RAM
	logic                 ram_we;
	logic [SW-1:0]        ram_raddr;
	ecal_pkg::count_t     ram_rdata;

	// clamped register values
	logic [4:0]    eff_n;
	logic [EW-1:0] steps_x;
	logic [EW-1:0] eff_steps_x;
	logic [LW-1:0] eff_steps;

	always_comb begin
		if (samples_q == 5'd0)
			eff_n = 5'd1;
		else if (samples_q > 5'd16)
			eff_n = 5'd16;
		else
			eff_n = samples_q;
		steps_x = EW'(steps_q);
		if (steps_x < EW'(2))
			eff_steps_x = EW'(2);
		else if (steps_x > EW'(MAX_STEPS))
			eff_steps_x = EW'(MAX_STEPS);
		else
			eff_steps_x = steps_x;
		eff_steps = eff_steps_x[LW-1:0];
	end

	// input fields
	logic [1:0]       in_op;
	ecal_pkg::count_t in_sample;
	ecal_pkg::count_t in_query;
	logic             in_beat;

	assign in_op     = s_tuser;
	assign in_sample = s_tdata[13:0];
	assign in_query  = s_tdata[27:14];
	assign s_tready  = (state_q == ST_IDLE);
	assign in_beat   = s_tvalid && s_tready;

	// sample accumulate
	logic [17:0] sum_new;
	logic [4:0]  taken_new;
	logic        full;

	assign sum_new   = sum_q + 18'(in_sample);
	assign taken_new = taken_q + 5'd1;
	assign full      = (loaded_q >= eff_steps);

	// scan: data of entry k_q arrives now; the last interval wraps to entry 0
	ecal_pkg::count_t b_rd;
	ecal_pkg::diff_t  ticks_s;
	ecal_pkg::count_t j_s;
	logic             hit;
	logic [LW-1:0]    k_next;
	logic [LW-1:0]    i_full;

	assign b_rd    = (k_q == eff_steps) ? r0_q : ram_rdata;
	assign ticks_s = ecal_pkg::step_diff(prev_q, b_rd);
	assign j_s     = q_q - prev_q;   // wraps at one revolution
	assign hit     = (ticks_s > ecal_pkg::diff_t'(0)) && (j_s < ticks_s[DSW-1:0]);
	assign k_next  = k_q + LW'(1);
	assign i_full  = k_q - LW'(1);

	always_comb begin
		if (state_q == ST_IDLE)
			ram_raddr = '0;
		else if (state_q == ST_RD0)
			ram_raddr = SW'(1);
		else
			ram_raddr = k_next[SW-1:0];
	end

	// divider step
	logic [DSW:0]   rem_sh;
	logic           rem_ge;
	logic [DSW:0]   rem_sub;

	assign rem_sh  = {rem_q, dvd_q[DVW-1]};
	assign rem_ge  = (rem_sh >= {1'b0, dvs_q});
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	// modulo step
	logic [AW:0] red_cmp;
	assign red_cmp = FULL_TURN_W << red_k_q;

	// write-back of a finished step reading
	ecal_pkg::count_t avg;
	assign avg    = quo_q[DSW-1:0];
	assign ram_we = (state_q == ST_WR);

	ecal_ram #(
		.WIDTH(ecal_pkg::CNT_W),
		.DEPTH(MAX_STEPS)
	) u_readings (
		.clk  (clk),
		.we   (ram_we),
		.waddr(loaded_q[SW-1:0]),
		.wdata(avg),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_q <= 5'd10;
			steps_q   <= 9'd200;
			angle_q   <= 16'd1800;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ecal_pkg::REG_SAMPLES: samples_q <= cfg_data[4:0];
				ecal_pkg::REG_STEPS:   steps_q   <= cfg_data[8:0];
				ecal_pkg::REG_ANGLE:   angle_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			loaded_q    <= '0;
			sum_q       <= '0;
			taken_q     <= '0;
			back_q      <= 1'b0;
			m_valid_q   <= 1'b0;
			div_query_q <= 1'b0;
		end else begin
			// ST_OUT reloads the output register itself
			if (m_valid_q && m_tready && (state_q != ST_OUT))
				m_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						case (in_op)
							ecal_pkg::OP_SAMPLE: begin
								if (!full) begin
									if (taken_new >= eff_n) begin
										sum_q       <= '0;
										taken_q     <= '0;
										div_query_q <= 1'b0;
										state_q     <= ST_DIV;
									end else begin
										sum_q   <= sum_new;
										taken_q <= taken_new;
									end
								end
							end
							ecal_pkg::OP_QUERY: begin
								if (!full || back_q)
									state_q <= ST_OUT;
								else
									state_q <= ST_RD0;
							end
							ecal_pkg::OP_RESTART: begin
								loaded_q <= '0;
								sum_q    <= '0;
								taken_q  <= '0;
								back_q   <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				ST_RD0:  state_q <= ST_SCAN;
				ST_SCAN: begin
					if (hit) begin
						state_q <= ST_MUL;
					end else if (k_q == eff_steps) begin
						state_q <= ST_OUT;
					end
				end
				ST_MUL: begin
					div_query_q <= 1'b1;
					state_q     <= ST_DIV;
				end
				ST_DIV: begin
					if (dcnt_q == 5'(DVW - 1))
						state_q <= div_query_q ? ST_ADD : ST_WR;
				end
				ST_ADD: state_q <= ST_RED;
				ST_RED: begin
					if (red_k_q == '0)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				ST_WR: begin
					if ((loaded_q == LW'(1)) &&
					    (ecal_pkg::step_diff(first_q, avg) < ecal_pkg::diff_t'(0)))
						back_q <= 1'b1;
					loaded_q <= loaded_q + LW'(1);
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				q_q <= in_query;
				// query answered at once: incomplete table or backwards wiring
				stat_q <= full ? ecal_pkg::STAT_BACKWARDS : ecal_pkg::STAT_INCOMPLETE;
				ang_q  <= '0;
				dvd_q  <= DVW'(sum_new);
				dvs_q  <= DSW'(eff_n);
				rem_q  <= '0;
				dcnt_q <= '0;
			end
			ST_RD0: begin
				r0_q   <= ram_rdata;
				prev_q <= ram_rdata;
				k_q    <= LW'(1);
			end
			ST_SCAN: begin
				prev_q  <= ram_rdata;
				k_q     <= k_next;
				i_q     <= i_full[SW-1:0];
				j_q     <= j_s;
				ticks_q <= ticks_s[DSW-1:0];
				stat_q  <= ecal_pkg::STAT_NO_INTERVAL;
			end
			ST_MUL: begin
				dvd_q  <= {14'd0, angle_q} * {16'd0, j_q};
				base_q <= BW'(angle_q) * BW'(i_q);
				dvs_q  <= ticks_q;
				rem_q  <= '0;
				dcnt_q <= '0;
			end
			ST_DIV: begin
				rem_q  <= rem_ge ? rem_sub[DSW-1:0] : rem_sh[DSW-1:0];
				quo_q  <= {quo_q[DVW-2:0], rem_ge};
				dvd_q  <= {dvd_q[DVW-2:0], 1'b0};
				dcnt_q <= dcnt_q + 5'd1;
			end
			ST_ADD: begin
				ang_q   <= AW'(base_q) + AW'(quo_q[15:0]);
				red_k_q <= KW'(KTOP);
				stat_q  <= ecal_pkg::STAT_OK;
			end
			ST_RED: begin
				if ({1'b0, ang_q} >= red_cmp)
					ang_q <= ang_q - red_cmp[AW-1:0];
				red_k_q <= red_k_q - KW'(1);
			end
			ST_OUT: begin
				if (!m_valid_q || m_tready) begin
					m_angle_q <= ang_q[18:0];
					m_stat_q  <= stat_q;
				end
			end
			ST_WR: begin
				if (loaded_q == '0)
					first_q <= avg;
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'd0, m_stat_q, m_angle_q};

	`include "assert_macros.svh"

	`ASSERT_CLK(a_loaded_bound, clk, arst_n, loaded_q <= LW'(MAX_STEPS))
	`ASSERT_CLK(a_taken_bound, clk, arst_n, taken_q < 5'd16)
	`ASSERT_CLK(a_write_not_full, clk, arst_n, ram_we |-> (loaded_q < eff_steps))
	`ASSERT_NEXT(a_mod_done, clk, arst_n, (state_q == ST_RED) && (red_k_q == '0), ang_q < AW'(ecal_pkg::FULL_TURN))
	`ASSERT_CLK(a_ok_angle_range, clk, arst_n, (m_valid_q && (m_stat_q != ecal_pkg::STAT_OK)) |-> (m_angle_q == 19'd0))

endmodule

@@ rtl/ecal_ram.sv @@
// ---------------------------------------------------------------------------
// ecal_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module ecal_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
